### hw/rtl/text_to_integer_parser_core_macros.svh
// Assertion helpers shared by the parser modules.
// Each expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef TEXT_TO_INTEGER_PARSER_CORE_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_CORE_MACROS_SVH

// Check a property on every edge outside reset
`define TTIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define TTIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ttip_pkg.sv
`timescale 1ns / 1ps
package ttip_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 1'd1;

    // Bases
    localparam logic [5:0] RADIX_AUTO  = 6'd0;
    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] BASE_OCT    = 6'd8;
    localparam logic [5:0] BASE_DEC    = 6'd10;
    localparam logic [5:0] BASE_HEX    = 6'd16;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_A_UP  = 8'd65;
    localparam logic [7:0] CH_Z_UP  = 8'd90;
    localparam logic [7:0] CH_X_UP  = 8'd88;
    localparam logic [7:0] CH_A_LO  = 8'd97;
    localparam logic [7:0] CH_Z_LO  = 8'd122;
    localparam logic [7:0] CH_X_LO  = 8'd120;
    localparam logic [7:0] DIGIT_LETTER_BASE = 8'd10;

    // Input item
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in;

    // Result item
    typedef struct packed {
        logic [63:0] value_bits;
        logic [15:0] end_offset;
        logic        range_error;
        logic        no_digits;
    } t_out;

    // Decoded digit
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_digit;

    // Status from datapath to controller
    typedef struct packed {
        logic is_space;
        logic is_sign;
        logic zero_path;
        logic is_x;
        logic begin_ok;
        logic cont_ok;
    } t_stat;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic set_sign;
        logic load_begin;
        logic load_hex;
        logic force_one;
        logic mac;
        logic use_begin;
        logic stop;
        logic end_pos;
        logic end_stop;
        logic end_zero;
        logic fin_load;
        logic clear;
    } t_cmd;

    // Map a character to its digit value, 0-9 then a-z / A-Z as 10-35
    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit d;
        d.valid = 1'b1;
        d.value = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = 6'(c - CH_ZERO);
        end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
            d.value = 6'(c - CH_A_LO + DIGIT_LETTER_BASE);
        end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
            d.value = 6'(c - CH_A_UP + DIGIT_LETTER_BASE);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

### hw/rtl/ttip_ctrl.sv
`timescale 1ns / 1ps
`include "text_to_integer_parser_core_macros.svh"
module ttip_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_last,
    input  ttip_pkg::t_stat i_stat,
    output ttip_pkg::t_cmd  o_cmd,
    output logic            o_out_valid,
    input  logic            i_out_ready
);

    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_START  = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    t_phase          r_phase, n_phase;
    logic            r_fin, n_fin;
    logic            r_out_valid;
    logic            w_acc;
    logic            w_slot_free;
    logic            w_begin;
    ttip_pkg::t_cmd  cmd;

    assign o_in_ready  = !r_fin;
    assign w_acc       = i_in_valid && !r_fin;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // Decode the parse phase into datapath commands
    always_comb begin
        cmd     = '0;
        n_phase = r_phase;
        n_fin   = r_fin;
        w_begin = 1'b0;
        if (w_acc) begin
            cmd.accept = 1'b1;
            case (r_phase)
                PH_SPACE: begin
                    if (i_stat.is_space) begin
                        n_phase = PH_SPACE;
                    end else if (i_stat.is_sign) begin
                        cmd.set_sign = 1'b1;
                        n_phase      = PH_START;
                    end else begin
                        w_begin = 1'b1;
                    end
                end
                PH_START: begin
                    w_begin = 1'b1;
                end
                PH_ZERO: begin
                    if (i_stat.is_x) begin
                        cmd.load_hex = 1'b1;
                        n_phase      = PH_DIGITS;
                    end else begin
                        cmd.force_one = 1'b1;
                        if (i_stat.cont_ok) begin
                            cmd.mac = 1'b1;
                            n_phase = PH_DIGITS;
                        end else begin
                            cmd.stop = 1'b1;
                            n_phase  = PH_DONE;
                        end
                    end
                end
                PH_DIGITS: begin
                    if (i_stat.cont_ok) begin
                        cmd.mac = 1'b1;
                    end else begin
                        cmd.stop = 1'b1;
                        n_phase  = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_SPACE;
                end
            endcase
            // First character of the number: pick the base, take the digit
            if (w_begin) begin
                cmd.load_begin = 1'b1;
                if (i_stat.zero_path) begin
                    n_phase = PH_ZERO;
                end else if (i_stat.begin_ok) begin
                    cmd.mac       = 1'b1;
                    cmd.use_begin = 1'b1;
                    n_phase       = PH_DIGITS;
                end else begin
                    cmd.stop = 1'b1;
                    n_phase  = PH_DONE;
                end
            end
            if (i_last) begin
                n_fin = 1'b1;
            end
        end
        // Wrap up the string once the output slot is free
        if (r_fin) begin
            cmd.end_pos  = (r_phase == PH_ZERO) || (r_phase == PH_DIGITS);
            cmd.end_stop = (r_phase == PH_DONE);
            cmd.end_zero = (r_phase == PH_ZERO);
            if (w_slot_free) begin
                cmd.fin_load = 1'b1;
                cmd.clear    = 1'b1;
                n_phase      = PH_SPACE;
                n_fin        = 1'b0;
            end
        end
    end

    // Hold phase and finish flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_fin   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_fin   <= n_fin;
        end
    end

    // Hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.fin_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `TTIP_ASSERT_NEXT(a_last_starts_fin, w_acc && i_last, r_fin, "last char did not start wrap-up")
    `TTIP_ASSERT_NEXT(a_fin_gives_result, cmd.fin_load, o_out_valid, "wrap-up gave no result")
    `TTIP_ASSERT_NEXT(a_fin_rearms, cmd.fin_load, (r_phase == PH_SPACE) && !r_fin, "parse not rearmed")

endmodule

### hw/rtl/ttip_dp.sv
`timescale 1ns / 1ps
`include "text_to_integer_parser_core_macros.svh"
module ttip_dp #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ttip_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ttip_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [7:0]                         i_char,
    input  ttip_pkg::t_cmd                     i_cmd,
    output ttip_pkg::t_stat                    o_stat,
    output ttip_pkg::t_out                     o_out_data
);

    localparam int PW = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;

    logic [5:0]        r_radix;
    logic              r_signed;
    logic              r_neg;
    logic [5:0]        r_base;
    logic [63:0]       r_acc;
    logic              r_ovf;
    logic [PW-1:0]     r_pos;
    logic              r_have;
    logic [PW-1:0]     r_stop;
    ttip_pkg::t_out    r_out;
    ttip_pkg::t_out    n_out;

    ttip_pkg::t_digit  w_dg;
    logic [5:0]        w_begin_base;
    logic [5:0]        w_mac_base;
    logic [69:0]       w_sum;
    logic              w_wrap;
    logic              w_zero_path;
    logic              w_have;
    logic [15:0]       w_end;
    logic [63:0]       w_neg_v;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= ttip_pkg::RADIX_RESET;
            r_signed <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ttip_pkg::CFG_RADIX:  r_radix  <= i_cfg_data;
                ttip_pkg::CFG_SIGNED: r_signed <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Classify the current character
    assign w_dg        = ttip_pkg::digit_of(i_char);
    assign w_zero_path = ((r_radix == ttip_pkg::RADIX_AUTO) || (r_radix == ttip_pkg::BASE_HEX))
                         && (i_char == ttip_pkg::CH_ZERO);

    always_comb begin
        if (w_zero_path) begin
            w_begin_base = (r_radix == ttip_pkg::RADIX_AUTO) ? ttip_pkg::BASE_OCT
                                                             : ttip_pkg::BASE_HEX;
        end else begin
            w_begin_base = (r_radix == ttip_pkg::RADIX_AUTO) ? ttip_pkg::BASE_DEC : r_radix;
        end
    end

    assign o_stat.is_space  = (i_char == ttip_pkg::CH_SPACE)
                              || ((i_char >= ttip_pkg::CH_TAB) && (i_char <= ttip_pkg::CH_CR));
    assign o_stat.is_sign   = (i_char == ttip_pkg::CH_PLUS) || (i_char == ttip_pkg::CH_MINUS);
    assign o_stat.zero_path = w_zero_path;
    assign o_stat.is_x      = (i_char == ttip_pkg::CH_X_LO) || (i_char == ttip_pkg::CH_X_UP);
    assign o_stat.begin_ok  = w_dg.valid && (w_begin_base != 6'd0) && (w_dg.value < w_begin_base);
    assign o_stat.cont_ok   = w_dg.valid && (r_base != 6'd0) && (w_dg.value < r_base);

    // Multiply-accumulate; any carry above bit 63 means overflow
    assign w_mac_base = i_cmd.use_begin ? w_begin_base : r_base;
    assign w_sum      = ({6'd0, r_acc} * {64'd0, w_mac_base}) + {64'd0, w_dg.value};
    assign w_wrap     = |w_sum[69:64];

    // Advance the parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_neg  <= 1'b0;
            r_base <= '0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
            r_pos  <= '0;
            r_have <= 1'b0;
            r_stop <= '0;
        end else begin
            if (i_cmd.accept && (r_pos != {PW{1'b1}})) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.set_sign) begin
                r_neg <= (i_char == ttip_pkg::CH_MINUS);
            end
            if (i_cmd.load_begin) begin
                r_base <= w_begin_base;
            end
            if (i_cmd.load_hex) begin
                r_base <= ttip_pkg::BASE_HEX;
            end
            if (i_cmd.force_one) begin
                r_have <= 1'b1;
            end
            if (i_cmd.mac) begin
                r_have <= 1'b1;
                if (w_wrap) begin
                    r_ovf <= 1'b1;
                    r_acc <= '1;
                end else if (!r_ovf) begin
                    r_acc <= w_sum[63:0];
                end
            end
            if (i_cmd.stop) begin
                r_stop <= r_pos;
            end
        end
    end

    // Form the result: sign, clamp and end offset
    assign w_have  = r_have || i_cmd.end_zero;
    assign w_neg_v = ~r_acc + 64'd1;

    always_comb begin
        if (i_cmd.end_pos) begin
            w_end = 16'(r_pos);
        end else if (i_cmd.end_stop) begin
            w_end = 16'(r_stop);
        end else begin
            w_end = '0;
        end
        n_out.end_offset  = w_end;
        n_out.range_error = r_ovf;
        n_out.no_digits   = 1'b0;
        if (r_signed) begin
            if (r_neg) begin
                if (r_acc[63] && (|r_acc[62:0])) begin
                    n_out.value_bits  = {1'b1, 63'd0};
                    n_out.range_error = 1'b1;
                end else begin
                    n_out.value_bits = w_neg_v;
                end
            end else if (r_acc[63]) begin
                n_out.value_bits  = {1'b0, {63{1'b1}}};
                n_out.range_error = 1'b1;
            end else begin
                n_out.value_bits = r_acc;
            end
        end else if (r_ovf) begin
            n_out.value_bits = '1;
        end else begin
            n_out.value_bits = r_neg ? w_neg_v : r_acc;
        end
        if (!w_have) begin
            n_out.value_bits  = '0;
            n_out.end_offset  = '0;
            n_out.range_error = 1'b0;
            n_out.no_digits   = 1'b1;
        end
    end

    // Hold the output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    `TTIP_ASSERT(a_ovf_saturates, !r_ovf || (&r_acc), "overflow without saturated accumulator")

endmodule

### hw/rtl/text_to_integer_parser_core.sv
// The last character's transfer sets the finish flag; the wrap-up then registers the result and its valid.
// Throughput: one character per cycle outside wrap-up; after each string's last character
// a wrap-up step follows, in which no character is taken; it waits while a result is held.
// Digit accumulation is one 64x6 multiply-add per character in the datapath.
// Reset (synchronous, active low) sets radix 10, signed mode, and an empty parse.
`timescale 1ns / 1ps
module text_to_integer_parser_core #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ttip_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ttip_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  ttip_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output ttip_pkg::t_out                     o_out_data
);

    ttip_pkg::t_cmd  w_cmd;
    ttip_pkg::t_stat w_stat;

    // Sequence the parse phases
    ttip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_last      (i_in_data.last_char),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    // Accumulate digits and form the result
    ttip_dp #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_char     (i_in_data.char_code),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule
